/* sv/dirty_rectangle_tracker_top_macros.svh */
// assertion macros for the dirty rectangle tracker
`ifndef DIRTY_RECTANGLE_TRACKER_TOP_MACROS_SVH
`define DIRTY_RECTANGLE_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define DRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/drt_pkg.sv */
`timescale 1ns / 1ps
package drt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OL_W_BITS      = 8;
  localparam int NSLOTS         = 16;
  localparam int SLOT_BITS      = 4;
  localparam int QDEPTH         = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTLINE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTLINE_WIDTH  = 2'd1;

  localparam logic KIND_AREA   = 1'b0;
  localparam logic KIND_BORDER = 1'b1;

  // slot layout: bit 3 selects the border group, bit 2 the swapped / old half
  localparam int SLOT_GRP_BIT = 3;
  localparam int SLOT_OLD_BIT = 2;

  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_TOP    = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_BOTTOM = 2'd3;

  localparam logic [1:0] BORDER_TOP    = 2'd0;
  localparam logic [1:0] BORDER_BOTTOM = 2'd1;
  localparam logic [1:0] BORDER_LEFT   = 2'd2;
  localparam logic [1:0] BORDER_RIGHT  = 2'd3;

  typedef struct packed {
    logic                 outline_enable;
    logic [OL_W_BITS-1:0] outline_width;
  } cfg_t;

  function automatic int job_bits(input int cb);
    return 16 * cb + 2 * OL_W_BITS + 1 + NSLOTS;
  endfunction

endpackage

/* sv/drt_fifo.sv */
`timescale 1ns / 1ps
`include "dirty_rectangle_tracker_top_macros.svh"
module drt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `DRT_ASSERT(a_cnt_bound, clk, rst_n, (cnt_r <= CNT_W'(DEPTH)), "queue count overflow")
  `DRT_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

/* sv/drt_front.sv */
`timescale 1ns / 1ps
module drt_front #(
  parameter int COORD_BITS = drt_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  drt_pkg::cfg_t                               cfg,
  input  logic                                        in_push,
  output logic                                        in_full,
  input  logic signed [COORD_BITS-1:0]                in_sel_left,
  input  logic signed [COORD_BITS-1:0]                in_sel_top,
  input  logic signed [COORD_BITS-1:0]                in_sel_right,
  input  logic signed [COORD_BITS-1:0]                in_sel_bottom,
  output logic                                        q_push,
  input  logic                                        q_full,
  output logic [drt_pkg::job_bits(COORD_BITS)-1:0]    q_data
);
  import drt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EB = CB + 2;
  localparam logic signed [EB-1:0] CMAX = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [EB-1:0] CMIN = {3'b111, {(CB-1){1'b0}}};
  localparam logic signed [EB-1:0] ONE  = EB'(1);

  typedef struct packed {
    logic signed [CB-1:0] x0;
    logic signed [CB-1:0] y0;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
  } rect_t;

  typedef struct packed {
    rect_t                area;
    rect_t                prev;
    rect_t                ol;
    rect_t                prev_ol;
    logic [OL_W_BITS-1:0] w;
    logic [OL_W_BITS-1:0] prev_w;
    logic                 ovl;
    logic [NSLOTS-1:0]    mask;
  } job_t;

  function automatic logic signed [EB-1:0] ext(input logic signed [CB-1:0] v);
    return {{(EB-CB){v[CB-1]}}, v};
  endfunction

  function automatic logic signed [EB-1:0] wext(input logic [OL_W_BITS-1:0] v);
    return {{(EB-OL_W_BITS){1'b0}}, v};
  endfunction

  function automatic logic signed [CB-1:0] sat(input logic signed [EB-1:0] v);
    if (v > CMAX) begin
      return CMAX[CB-1:0];
    end else if (v < CMIN) begin
      return CMIN[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  function automatic logic is_empty(input rect_t r);
    return (r.x1 <= r.x0) || (r.y1 <= r.y0);
  endfunction

  rect_t                prev_area_r;
  rect_t                prev_ol_r;
  logic [OL_W_BITS-1:0] prev_w_r;
  rect_t                area, ol;
  logic [OL_W_BITS-1:0] wlt, wrb;
  logic [OL_W_BITS:0]   wsum;
  logic                 accept;
  logic                 ovl;
  logic [NSLOTS-1:0]    mask;
  job_t                 job;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign q_push  = accept;

  always_comb begin
    wsum    = {1'b0, cfg.outline_width} + (OL_W_BITS+1)'(1);
    wrb     = wsum[OL_W_BITS:1];
    wlt     = {1'b0, cfg.outline_width[OL_W_BITS-1:1]};
    area.x0 = in_sel_left;
    area.y0 = in_sel_top;
    area.x1 = sat(ext(in_sel_right) + ONE);
    area.y1 = sat(ext(in_sel_bottom) + ONE);
    ol.x0   = sat(ext(in_sel_left) - wext(wlt));
    ol.y0   = sat(ext(in_sel_top) - wext(wlt));
    ol.x1   = sat(ext(in_sel_right) + wext(wrb));
    ol.y1   = sat(ext(in_sel_bottom) + wext(wrb));
    ovl     = !((area.x0 >= prev_area_r.x1) || (prev_area_r.x0 >= area.x1) ||
                (area.y0 >= prev_area_r.y1) || (prev_area_r.y0 >= area.y1));
    mask[0] = ovl ? (area.x0 < prev_area_r.x0) : !is_empty(area);
    mask[1] = ovl ? (area.y0 < prev_area_r.y0) : !is_empty(prev_area_r);
    mask[2] = ovl && (area.x1 < prev_area_r.x1);
    mask[3] = ovl && (area.y1 < prev_area_r.y1);
    mask[4] = ovl && (prev_area_r.x0 < area.x0);
    mask[5] = ovl && (prev_area_r.y0 < area.y0);
    mask[6] = ovl && (prev_area_r.x1 < area.x1);
    mask[7] = ovl && (prev_area_r.y1 < area.y1);
    mask[NSLOTS-1:8] = {(NSLOTS-8){cfg.outline_enable}};
    job.area    = area;
    job.prev    = prev_area_r;
    job.ol      = ol;
    job.prev_ol = prev_ol_r;
    job.w       = cfg.outline_width;
    job.prev_w  = prev_w_r;
    job.ovl     = ovl;
    job.mask    = mask;
  end

  assign q_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_area_r <= '0;
      prev_ol_r   <= '0;
      prev_w_r    <= '0;
    end else if (accept) begin
      prev_area_r <= area;
      if (cfg.outline_enable) begin
        prev_ol_r <= ol;
        prev_w_r  <= cfg.outline_width;
      end
    end
  end

endmodule

/* sv/drt_back.sv */
`timescale 1ns / 1ps
`include "dirty_rectangle_tracker_top_macros.svh"
module drt_back #(
  parameter int COORD_BITS = drt_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  input  logic [drt_pkg::job_bits(COORD_BITS)-1:0] q_data,
  output logic                                     out_empty,
  input  logic                                     out_pop,
  output logic signed [COORD_BITS-1:0]             out_rect_left,
  output logic signed [COORD_BITS-1:0]             out_rect_top,
  output logic signed [COORD_BITS-1:0]             out_rect_right,
  output logic signed [COORD_BITS-1:0]             out_rect_bottom,
  output logic                                     out_rect_kind,
  output logic                                     out_last_of_run
);
  import drt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EB = CB + 2;
  localparam logic signed [EB-1:0] CMAX = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [EB-1:0] CMIN = {3'b111, {(CB-1){1'b0}}};

  typedef struct packed {
    logic signed [CB-1:0] x0;
    logic signed [CB-1:0] y0;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
  } rect_t;

  typedef struct packed {
    rect_t                area;
    rect_t                prev;
    rect_t                ol;
    rect_t                prev_ol;
    logic [OL_W_BITS-1:0] w;
    logic [OL_W_BITS-1:0] prev_w;
    logic                 ovl;
    logic [NSLOTS-1:0]    mask;
  } job_t;

  function automatic logic signed [EB-1:0] ext(input logic signed [CB-1:0] v);
    return {{(EB-CB){v[CB-1]}}, v};
  endfunction

  function automatic logic signed [EB-1:0] wext(input logic [OL_W_BITS-1:0] v);
    return {{(EB-OL_W_BITS){1'b0}}, v};
  endfunction

  function automatic logic signed [CB-1:0] sat(input logic signed [EB-1:0] v);
    if (v > CMAX) begin
      return CMAX[CB-1:0];
    end else if (v < CMIN) begin
      return CMIN[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  job_t                  qjob;
  job_t                  job_r;
  logic [NSLOTS-1:0]     mask_r, mask_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rect_t                 out_rect_r;
  logic                  out_kind_r;
  logic                  out_last_r;
  logic [NSLOTS-1:0]     pick, rem;
  logic [SLOT_BITS-1:0]  slot;
  logic                  have, space, adv, load;
  rect_t                 a, b, bx, cand;
  logic signed [EB-1:0]  bw;

  assign qjob = q_data;

  always_comb begin
    pick = mask_r & (~mask_r + NSLOTS'(1));
    rem  = mask_r & ~pick;
    slot = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (pick[i]) begin
        slot = slot | SLOT_BITS'(i);
      end
    end
  end

  assign have  = (mask_r != '0);
  assign space = !out_valid_r || out_pop;
  assign adv   = have && space;
  assign load  = !q_empty && (!have || (adv && (rem == '0)));
  assign q_pop = load;

  always_comb begin
    a    = job_r.area;
    b    = job_r.prev;
    bx   = job_r.ol;
    bw   = wext(job_r.w);
    cand = job_r.area;
    if (slot[SLOT_GRP_BIT]) begin
      if (slot[SLOT_OLD_BIT]) begin
        bx = job_r.prev_ol;
        bw = wext(job_r.prev_w);
      end
      cand = bx;
      case (slot[1:0])
        BORDER_TOP:    cand.y1 = sat(ext(bx.y0) + bw);
        BORDER_BOTTOM: cand.y0 = sat(ext(bx.y1) - bw);
        BORDER_LEFT:   cand.x1 = sat(ext(bx.x0) + bw);
        BORDER_RIGHT:  cand.x0 = sat(ext(bx.x1) - bw);
        default:       cand = bx;
      endcase
    end else if (!job_r.ovl) begin
      cand = slot[0] ? job_r.prev : job_r.area;
    end else begin
      if (slot[SLOT_OLD_BIT]) begin
        a = job_r.prev;
        b = job_r.area;
      end
      case (slot[1:0])
        EDGE_LEFT:   cand = '{a.x0, a.y0, b.x0, a.y1};
        EDGE_TOP:    cand = '{a.x0, a.y0, a.x1, b.y0};
        EDGE_RIGHT:  cand = '{a.x1, b.y0, b.x1, b.y1};
        EDGE_BOTTOM: cand = '{b.x0, a.y1, b.x1, b.y1};
        default:     cand = a;
      endcase
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = qjob.mask;
    end else if (adv) begin
      mask_nxt = rem;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= qjob;
    end
    if (adv) begin
      out_rect_r <= cand;
      out_kind_r <= slot[SLOT_GRP_BIT] ? KIND_BORDER : KIND_AREA;
      out_last_r <= (rem == '0);
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_rect_left   = out_rect_r.x0;
  assign out_rect_top    = out_rect_r.y0;
  assign out_rect_right  = out_rect_r.x1;
  assign out_rect_bottom = out_rect_r.y1;
  assign out_rect_kind   = out_kind_r;
  assign out_last_of_run = out_last_r;

  `DRT_ASSERT_IMPL(a_pick_onehot, clk, rst_n, have, $onehot(pick), "slot pick not one-hot")
  `DRT_ASSERT(a_hold_on_stall, clk, rst_n, (out_valid_r && !out_pop && have) |=> $stable(mask_r), "slot advanced while result stalled")
  `DRT_ASSERT_IMPL(a_load_needs_job, clk, rst_n, q_pop, !q_empty, "job taken from empty queue")

endmodule

/* sv/dirty_rectangle_tracker_top.sv */
`timescale 1ns / 1ps
// dirty rectangle tracker for a rubber-band selection
// input: a queue-style push/full port with the inclusive selection corners;
//   a transaction happens when in_push is high and in_full is low
// output: a queue-style empty/pop port; while out_empty is low the oldest
//   repaint rectangle is on the out_ ports, taken when out_pop is high
// config: cfg_valid/cfg_ready write port, index 0 outline_enable, index 1
//   outline_width; cfg_ready is always high, write only while idle
// each input gives 0 to 12 rectangles: area difference strips first, then
//   eight outline border strips when the outline is on; out_last_of_run
//   marks the final one of an input
// path: job queue, then job register, then the output register
// throughput: one rectangle per cycle from the back-end sequencer while the
//   output is not stalled; a 2-entry job queue lets new inputs come in while
//   earlier ones are still being emitted
// output stall: the output register holds, the sequencer waits, the queue
//   fills and in_full rises
// reset: stored previous area and outline cleared to zero, config cleared,
//   queue and output emptied
module dirty_rectangle_tracker_top #(
  parameter int COORD_BITS = drt_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [COORD_BITS-1:0]         in_sel_left,
  input  logic signed [COORD_BITS-1:0]         in_sel_top,
  input  logic signed [COORD_BITS-1:0]         in_sel_right,
  input  logic signed [COORD_BITS-1:0]         in_sel_bottom,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [COORD_BITS-1:0]         out_rect_left,
  output logic signed [COORD_BITS-1:0]         out_rect_top,
  output logic signed [COORD_BITS-1:0]         out_rect_right,
  output logic signed [COORD_BITS-1:0]         out_rect_bottom,
  output logic                                 out_rect_kind,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [drt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [drt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import drt_pkg::*;

  localparam int JOB_W = job_bits(COORD_BITS);

  cfg_t             cfg_r, cfg_nxt;
  logic             q_push, q_full, q_pop, q_empty;
  logic [JOB_W-1:0] q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUTLINE_ENABLE: cfg_nxt.outline_enable = cfg_data[0];
        CFG_OUTLINE_WIDTH:  cfg_nxt.outline_width  = cfg_data[OL_W_BITS-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  drt_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_sel_left   (in_sel_left),
    .in_sel_top    (in_sel_top),
    .in_sel_right  (in_sel_right),
    .in_sel_bottom (in_sel_bottom),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_data        (q_din)
  );

  drt_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  drt_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (q_dout),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_rect_left   (out_rect_left),
    .out_rect_top    (out_rect_top),
    .out_rect_right  (out_rect_right),
    .out_rect_bottom (out_rect_bottom),
    .out_rect_kind   (out_rect_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule
